### rtl/wps_pkg.sv
package wps_pkg;

    // Table and field sizes
    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_IDX_W      = 4;
    localparam int COORD_W       = 24;
    localparam int STEP_W        = 20;
    localparam int CNT_W         = 5;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_W         = 24;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;     // coordinate difference
    localparam int RAD_W  = 2 * DIFF_W;      // sum of two squares
    localparam int REM_W  = DIFF_W + 1;      // root / divider remainder
    localparam int SUB_W  = REM_W + 2;       // shared subtractor
    localparam int LIM_W  = 2 * STEP_W;      // step squared
    localparam int ITER_W = 5;

    // Stream word layout
    localparam int IN_BITS    = WP_IDX_W + 2 * COORD_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * COORD_W + WP_IDX_W + 2;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WP_COUNT  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } wps_state_t;

    typedef enum logic [4:0] {
        C_IDLE,
        C_SQX,
        C_SQY,
        C_SUM,
        C_ROOT,
        C_LEN,
        C_MULX,
        C_LDX,
        C_DIVX,
        C_MULY,
        C_LDY,
        C_DIVY,
        C_MOVE,
        C_ERR,
        C_ESQX,
        C_ESQY,
        C_ECMP,
        C_DONE
    } wps_core_state_t;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] tgt_x;
        logic signed [COORD_W-1:0] tgt_y;
        logic        [STEP_W-1:0]  step;
    } wps_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic                      reached;
    } wps_rsp_t;

endpackage

### rtl/waypoint_path_stepper.sv
// Moves a point along a table of up to 16 waypoints, one fixed step length per tick.
// Each input word (s_tuser = kind) is a tick, a waypoint load, a restart at the
// start registers or an unused kind; each one gives exactly one result word with
// the position, the segment and the reached/finished flags. Config writes
// (cfg_wr_en) are taken at any edge but must only be issued while the block is
// idle. A tick that moves the point runs through one shared 25x25 multiplier and
// one shared 28-bit subtractor: a square root and two restoring divisions set its
// time, and s_tready stays low until its result word is loaded into the output
// register. A tick whose position already sits on its target stops after the root.
// Loads, restarts, unused kinds and ticks that skip the core go straight to the
// output state. A result word sits in an output register, so the next word is
// accepted while it waits; if that register is still full when a new result is
// ready, the block holds.
module waypoint_path_stepper
    import wps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] wp_index, [27:4] wp_x, [51:28] wp_y, rest zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]      s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [23:0] pos_x, [47:24] pos_y, [51:48] segment, [52] reached, [53] finished
    output logic [M_TDATA_W-1:0]   m_tdata,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    wps_state_t state_reg, state_next;

    logic signed [COORD_W-1:0]   start_x_reg, start_y_reg;
    logic        [STEP_W-1:0]    step_reg;
    logic        [CNT_W-1:0]     count_reg;

    logic signed [COORD_W-1:0]   pos_x_reg, pos_x_next;
    logic signed [COORD_W-1:0]   pos_y_reg, pos_y_next;
    logic        [WP_IDX_W-1:0]  seg_reg, seg_next;
    logic                        reached_reg, reached_next;
    logic                        finished_reg, finished_next;

    logic [2*COORD_W-1:0]        wp_mem [MAX_WAYPOINTS];
    logic [2*COORD_W-1:0]        wp_rd_reg;

    logic                        m_tvalid_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;

    logic                        in_fire;
    logic                        out_load;
    logic [WP_IDX_W-1:0]         in_idx;
    logic signed [COORD_W-1:0]   in_x, in_y;
    logic [CNT_W-1:0]            count_eff;
    logic [CNT_W-1:0]            seg_plus;
    logic                        path_ok;
    logic                        core_start;

    wps_req_t core_req;
    wps_rsp_t core_rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign in_idx = s_tdata[WP_IDX_W-1:0];
    assign in_x   = s_tdata[WP_IDX_W + COORD_W - 1:WP_IDX_W];
    assign in_y   = s_tdata[WP_IDX_W + 2*COORD_W - 1:WP_IDX_W + COORD_W];

    assign count_eff = (count_reg > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : count_reg;
    assign seg_plus  = {1'b0, seg_reg} + 1'b1;
    assign path_ok   = (count_eff >= CNT_W'(2));

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            step_reg    <= '0;
            count_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_START_X:  start_x_reg <= cfg_wdata[COORD_W-1:0];
                REG_START_Y:  start_y_reg <= cfg_wdata[COORD_W-1:0];
                REG_STEP:     step_reg    <= cfg_wdata[STEP_W-1:0];
                REG_WP_COUNT: count_reg   <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // waypoint table, {y, x}; read address tracks the next target
    always_ff @(posedge aclk) begin
        if (in_fire && s_tuser == KIND_LOAD) begin
            wp_mem[in_idx] <= {in_y, in_x};
        end
        wp_rd_reg <= wp_mem[seg_plus[WP_IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            seg_reg      <= '0;
            reached_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            seg_reg      <= seg_next;
            reached_reg  <= reached_next;
            finished_reg <= finished_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        seg_next      = seg_reg;
        reached_next  = reached_reg;
        finished_next = finished_reg;
        core_start    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    reached_next  = 1'b0;
                    finished_next = 1'b0;
                    state_next    = S_OUT;
                    case (s_tuser)
                        KIND_TICK: begin
                            if (path_ok && seg_plus < count_eff) begin
                                state_next = S_START;
                            end else begin
                                finished_next = path_ok;
                            end
                        end
                        KIND_LOAD: begin
                        end
                        KIND_RESTART: begin
                            pos_x_next = start_x_reg;
                            pos_y_next = start_y_reg;
                            seg_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_START: begin
                core_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (core_rsp.done) begin
                    pos_x_next = core_rsp.new_x;
                    pos_y_next = core_rsp.new_y;
                    if (core_rsp.reached) begin
                        seg_next     = seg_plus[WP_IDX_W-1:0];
                        reached_next = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign core_req.start = core_start;
    assign core_req.pos_x = pos_x_reg;
    assign core_req.pos_y = pos_y_reg;
    assign core_req.tgt_x = wp_rd_reg[COORD_W-1:0];
    assign core_req.tgt_y = wp_rd_reg[2*COORD_W-1:COORD_W];
    assign core_req.step  = step_reg;

    wps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (core_req),
        .rsp_o   (core_rsp)
    );

    // output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - OUT_BITS){1'b0}}, finished_reg, reached_reg,
                            seg_reg, pos_y_reg, pos_x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        core_rsp.done |-> state_reg == S_WAIT)
        else $error("core result outside wait state");

    a_word_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result word loaded outside output state");

    a_word_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word dropped or changed while stalled");

endmodule

### rtl/wps_core.sv
module wps_core
    import wps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  wps_req_t req_i,
    output wps_rsp_t rsp_o
);

    localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(DIFF_W - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(STEP_W - 1);

    wps_core_state_t state_reg, state_next;

    logic signed [DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [DIFF_W-1:0]  dy_reg, dy_next;
    logic        [RAD_W-1:0]   mul_reg, mul_next;
    logic        [RAD_W-1:0]   rad_reg, rad_next;
    logic        [REM_W-1:0]   rem_reg, rem_next;
    logic        [DIFF_W-1:0]  root_reg, root_next;
    logic        [STEP_W-1:0]  quo_reg, quo_next;
    logic        [STEP_W-1:0]  qx_reg, qx_next;
    logic        [LIM_W-1:0]   lim_reg, lim_next;
    logic        [ITER_W-1:0]  cnt_reg, cnt_next;
    logic signed [COORD_W-1:0] nx_reg, nx_next;
    logic signed [COORD_W-1:0] ny_reg, ny_next;
    logic                      reached_reg, reached_next;

    // shared multiplier and subtractor
    logic [DIFF_W-1:0] mul_a, mul_b;
    logic [RAD_W-1:0]  mul_p;
    logic [SUB_W-1:0]  sub_a, sub_b, sub_d;
    logic              sub_ge;

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] r;
        begin
            r = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            return r;
        end
    endfunction

    // position plus signed move, saturated to the coordinate range
    function automatic logic signed [COORD_W-1:0] move_coord(
        input logic signed [COORD_W-1:0] p,
        input logic                      neg,
        input logic        [STEP_W-1:0]  q
    );
        logic signed [COORD_W+1:0] qe;
        logic signed [COORD_W+1:0] sum;
        logic signed [COORD_W-1:0] r;
        begin
            qe  = {{(COORD_W + 2 - STEP_W){1'b0}}, q};
            sum = {{2{p[COORD_W-1]}}, p} + (neg ? -qe : qe);
            if (sum[COORD_W+1:COORD_W-1] == 3'b000 || sum[COORD_W+1:COORD_W-1] == 3'b111) begin
                r = sum[COORD_W-1:0];
            end else if (sum[COORD_W+1]) begin
                r = {1'b1, {(COORD_W - 1){1'b0}}};
            end else begin
                r = {1'b0, {(COORD_W - 1){1'b1}}};
            end
            return r;
        end
    endfunction

    assign mul_p  = mul_a * mul_b;
    assign sub_d  = sub_a - sub_b;
    assign sub_ge = (sub_a >= sub_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        mul_reg     <= mul_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        quo_reg     <= quo_next;
        qx_reg      <= qx_next;
        lim_reg     <= lim_next;
        cnt_reg     <= cnt_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        reached_reg <= reached_next;
    end

    always_comb begin
        state_next   = state_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        mul_next     = mul_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        quo_next     = quo_reg;
        qx_next      = qx_reg;
        lim_next     = lim_reg;
        cnt_next     = cnt_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        reached_next = reached_reg;
        mul_a        = '0;
        mul_b        = '0;
        sub_a        = '0;
        sub_b        = '0;

        case (state_reg)
            C_IDLE: begin
                if (req_i.start) begin
                    dx_next = {req_i.tgt_x[COORD_W-1], req_i.tgt_x}
                            - {req_i.pos_x[COORD_W-1], req_i.pos_x};
                    dy_next = {req_i.tgt_y[COORD_W-1], req_i.tgt_y}
                            - {req_i.pos_y[COORD_W-1], req_i.pos_y};
                    state_next = C_SQX;
                end
            end
            C_SQX: begin
                mul_a      = mag(dx_reg);
                mul_b      = mag(dx_reg);
                mul_next   = mul_p;
                state_next = C_SQY;
            end
            C_SQY: begin
                mul_a      = mag(dy_reg);
                mul_b      = mag(dy_reg);
                rad_next   = mul_reg;
                mul_next   = mul_p;
                state_next = C_SUM;
            end
            C_SUM: begin
                rad_next   = rad_reg + mul_reg;
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = ROOT_LAST;
                state_next = C_ROOT;
            end
            C_ROOT: begin
                // one root bit per cycle: bring down two radicand bits, try 4*root+1
                sub_a     = {rem_reg, rad_reg[RAD_W-1 -: 2]};
                sub_b     = {1'b0, root_reg, 2'b01};
                rem_next  = sub_ge ? sub_d[REM_W-1:0] : sub_a[REM_W-1:0];
                root_next = {root_reg[DIFF_W-2:0], sub_ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = C_LEN;
                end
            end
            C_LEN: begin
                if (root_reg == '0) begin
                    nx_next      = req_i.pos_x;
                    ny_next      = req_i.pos_y;
                    reached_next = 1'b0;
                    state_next   = C_DONE;
                end else begin
                    state_next = C_MULX;
                end
            end
            C_MULX, C_MULY: begin
                mul_a      = (state_reg == C_MULX) ? mag(dx_reg) : mag(dy_reg);
                mul_b      = DIFF_W'(req_i.step);
                mul_next   = mul_p;
                state_next = (state_reg == C_MULX) ? C_LDX : C_LDY;
            end
            C_LDX, C_LDY: begin
                // quotient never exceeds step, so the high part is already below length
                rem_next   = {1'b0, mul_reg[STEP_W + DIFF_W - 1:STEP_W]};
                quo_next   = mul_reg[STEP_W-1:0];
                cnt_next   = DIV_LAST;
                state_next = (state_reg == C_LDX) ? C_DIVX : C_DIVY;
            end
            C_DIVX, C_DIVY: begin
                sub_a    = {2'b00, rem_reg[DIFF_W-1:0], quo_reg[STEP_W-1]};
                sub_b    = {3'b000, root_reg};
                rem_next = {1'b0, (sub_ge ? sub_d[DIFF_W-1:0] : sub_a[DIFF_W-1:0])};
                quo_next = {quo_reg[STEP_W-2:0], sub_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (state_reg == C_DIVX) begin
                        qx_next    = {quo_reg[STEP_W-2:0], sub_ge};
                        state_next = C_MULY;
                    end else begin
                        state_next = C_MOVE;
                    end
                end
            end
            C_MOVE: begin
                nx_next    = move_coord(req_i.pos_x, dx_reg[DIFF_W-1], qx_reg);
                ny_next    = move_coord(req_i.pos_y, dy_reg[DIFF_W-1], quo_reg);
                state_next = C_ERR;
            end
            C_ERR: begin
                dx_next    = {req_i.tgt_x[COORD_W-1], req_i.tgt_x} - {nx_reg[COORD_W-1], nx_reg};
                dy_next    = {req_i.tgt_y[COORD_W-1], req_i.tgt_y} - {ny_reg[COORD_W-1], ny_reg};
                mul_a      = DIFF_W'(req_i.step);
                mul_b      = DIFF_W'(req_i.step);
                mul_next   = mul_p;
                state_next = C_ESQX;
            end
            C_ESQX: begin
                lim_next   = mul_reg[LIM_W-1:0];
                mul_a      = mag(dx_reg);
                mul_b      = mag(dx_reg);
                mul_next   = mul_p;
                state_next = C_ESQY;
            end
            C_ESQY: begin
                rad_next   = mul_reg;
                mul_a      = mag(dy_reg);
                mul_b      = mag(dy_reg);
                mul_next   = mul_p;
                state_next = C_ECMP;
            end
            C_ECMP: begin
                reached_next = ((rad_reg + mul_reg) < RAD_W'(lim_reg));
                state_next   = C_DONE;
            end
            C_DONE: begin
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign rsp_o.done    = (state_reg == C_DONE);
    assign rsp_o.new_x   = nx_reg;
    assign rsp_o.new_y   = ny_reg;
    assign rsp_o.reached = reached_reg;

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_o.done |=> !rsp_o.done)
        else $error("core done held for more than one cycle");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req_i.start |-> state_reg == C_IDLE)
        else $error("core started while busy");

    a_reach_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp_o.done && rsp_o.reached) |-> req_i.step != '0)
        else $error("waypoint reached with zero step");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wps_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint COORD_HI = 64'sd8388607;
    localparam longint COORD_LO = -64'sd8388608;
    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [WP_IDX_W-1:0]       segment;
        logic                      reached;
        logic                      finished;
    } position_word_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    // Predicted block state
    logic signed [COORD_W-1:0] start_x_r, start_y_r;
    logic [STEP_W-1:0] step_r;
    logic [CNT_W-1:0] count_r;
    logic signed [COORD_W-1:0] cur_x, cur_y;
    logic [WP_IDX_W-1:0] cur_seg;
    logic signed [COORD_W-1:0] table_x [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] table_y [MAX_WAYPOINTS];

    position_word_t pending_positions[$];
    int fail_count = 0;
    int sent_items = 0;
    int idle_cycles = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    waypoint_path_stepper dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > COORD_HI) return COORD_W'(COORD_HI);
        if (v < COORD_LO) return COORD_W'(COORD_LO);
        return COORD_W'(v);
    endfunction

    function automatic longint floor_root(input longint n);
        longint r, c;
        r = 0;
        for (int b = 26; b >= 0; b--) begin
            c = r | (longint'(1) << b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    task automatic step_position(input logic [KIND_W-1:0] kind, input logic [WP_IDX_W-1:0] idx,
                                 input logic signed [COORD_W-1:0] wx,
                                 input logic signed [COORD_W-1:0] wy);
        position_word_t w;
        int eff, t;
        longint tx, ty, dx, dy, len, st, ex, ey;
        w.reached = 1'b0;
        w.finished = 1'b0;
        case (kind)
            KIND_LOAD: begin
                table_x[idx] = wx;
                table_y[idx] = wy;
            end
            KIND_RESTART: begin
                cur_x = start_x_r;
                cur_y = start_y_r;
                cur_seg = '0;
            end
            KIND_TICK: begin
                eff = (count_r > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(count_r);
                if (eff >= 2) begin
                    if (int'(cur_seg) + 1 < eff) begin
                        t = int'(cur_seg) + 1;
                        tx = table_x[t];
                        ty = table_y[t];
                        dx = tx - cur_x;
                        dy = ty - cur_y;
                        len = floor_root(dx * dx + dy * dy);
                        if (len != 0) begin
                            st = longint'(step_r);
                            // signed division truncates toward zero
                            cur_x = clamp_coord(cur_x + (dx * st) / len);
                            cur_y = clamp_coord(cur_y + (dy * st) / len);
                            ex = tx - cur_x;
                            ey = ty - cur_y;
                            if (ex * ex + ey * ey < st * st) begin
                                cur_seg = WP_IDX_W'(t);
                                w.reached = 1'b1;
                            end
                        end
                    end else begin
                        w.finished = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        w.pos_x = cur_x;
        w.pos_y = cur_y;
        w.segment = cur_seg;
        pending_positions.push_back(w);
    endtask

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [WP_IDX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] wx,
                             input logic signed [COORD_W-1:0] wy);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(S_TDATA_W - IN_BITS){1'b0}}, wy, wx, idx};
        do @(posedge aclk); while (s_tready !== 1'b1);
        step_position(kind, idx, wx, wy);
        if (kind != KIND_UNUSED) sent_items++;
    endtask

    task automatic send_tick();
        send_word(KIND_TICK, WP_IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic send_restart();
        send_word(KIND_RESTART, WP_IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Drop valid and hold until every expected word is back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        case (addr)
            REG_START_X:  start_x_r = val;
            REG_START_Y:  start_y_r = val;
            REG_STEP:     step_r = val[STEP_W-1:0];
            REG_WP_COUNT: count_r = val[CNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Unused upper bits of step and count carry junk
    task automatic set_regs(input logic signed [COORD_W-1:0] sx,
                            input logic signed [COORD_W-1:0] sy,
                            input logic [STEP_W-1:0] st, input logic [CNT_W-1:0] cnt);
        wait_drained();
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_STEP, {(CFG_W - STEP_W)'($urandom), st});
        write_reg(REG_WP_COUNT, {(CFG_W - CNT_W)'($urandom), cnt});
    endtask

    task automatic test_empty_table();
        send_tick();
        send_word(KIND_UNUSED, WP_IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic test_single_segment();
        set_regs(24'sd0, 24'sd0, 20'd1024, 5'd1);
        send_word(KIND_LOAD, 4'd0, 24'sd0, 24'sd0);
        send_word(KIND_LOAD, 4'd1, 24'sd2560, 24'sd0);
        send_tick();
        set_regs(24'sd0, 24'sd0, 20'd1024, 5'd2);
        send_restart();
        repeat (3) send_tick();
    endtask

    task automatic test_zero_cases();
        // start on the target: zero length
        set_regs(24'sd2560, 24'sd0, 20'd1024, 5'd2);
        send_restart();
        send_tick();
        set_regs(24'sd0, 24'sd0, 20'd0, 5'd2);
        send_restart();
        send_tick();
    endtask

    task automatic test_saturation();
        send_word(KIND_LOAD, 4'd1, COORD_W'(COORD_HI), COORD_W'(COORD_LO));
        set_regs(COORD_W'(COORD_HI - 100), COORD_W'(COORD_LO + 100), 20'hFFFFF, 5'd2);
        send_restart();
        repeat (2) send_tick();
        // corner to corner: widest differences
        send_word(KIND_LOAD, 4'd1, COORD_W'(COORD_LO), COORD_W'(COORD_HI));
        set_regs(COORD_W'(COORD_HI), COORD_W'(COORD_LO), 20'hFFFFF, 5'd2);
        send_restart();
        repeat (2) send_tick();
    endtask

    task automatic test_random_paths();
        int base, phase, eff, n_ticks, span, pick;
        longint px, py, ox, oy;
        logic signed [COORD_W-1:0] sx, sy, wx, wy;
        logic [STEP_W-1:0] st;
        logic [CNT_W-1:0] cnt;
        base = sent_items;
        phase = 0;
        while (sent_items - base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: st = '0;
                1: st = 20'hFFFFF;
                2: st = STEP_W'($urandom_range(1, 16));
                default: st = STEP_W'($urandom_range(64, 20000));
            endcase
            pick = $urandom_range(0, 19);
            if (phase == 0) cnt = 5'd31;
            else if (phase == 1 || pick == 0) cnt = 5'd0;
            else if (pick == 1) cnt = 5'd1;
            else if (pick == 2) cnt = CNT_W'($urandom_range(17, 31));
            else if (pick == 3) cnt = 5'd16;
            else cnt = CNT_W'($urandom_range(2, 6));
            if ($urandom_range(0, 7) == 0) begin
                sx = $urandom_range(0, 1) ? COORD_W'(COORD_HI) : COORD_W'(COORD_LO);
                sy = $urandom_range(0, 1) ? COORD_W'(COORD_HI) : COORD_W'(COORD_LO);
            end else begin
                sx = COORD_W'($urandom);
                sy = COORD_W'($urandom);
            end
            set_regs(sx, sy, st, cnt);
            eff = (cnt > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(cnt);

            // fresh path: every slot that a tick can read gets loaded
            px = sx;
            py = sy;
            for (int i = 1; i < eff; i++) begin
                pick = $urandom_range(0, 14);
                if (pick == 0) begin
                    wx = COORD_W'($urandom);
                    wy = COORD_W'($urandom);
                end else begin
                    span = int'(st) * $urandom_range(1, 12) + $urandom_range(0, 255);
                    ox = (pick == 1) ? 0 : longint'($urandom_range(0, 2 * span)) - span;
                    oy = (pick == 1) ? 0 : longint'($urandom_range(0, 2 * span)) - span;
                    wx = clamp_coord(px + ox);
                    wy = clamp_coord(py + oy);
                end
                send_word(KIND_LOAD, WP_IDX_W'(i), wx, wy);
                px = wx;
                py = wy;
            end
            send_restart();

            n_ticks = eff * 14 + $urandom_range(2, 12);
            for (int n = 0; n < n_ticks; n++) begin
                case ($urandom_range(0, 29))
                    0: send_word(KIND_LOAD, WP_IDX_W'($urandom), COORD_W'($urandom),
                                 COORD_W'($urandom));
                    1: send_word(KIND_UNUSED, WP_IDX_W'($urandom), COORD_W'($urandom),
                                 COORD_W'($urandom));
                    2: send_restart();
                    3: begin
                        wait_drained();
                        send_tick();
                    end
                    default: send_tick();
                endcase
            end
            phase++;
        end
    endtask

    // Result side: random stalls, compare each word with the oldest prediction
    initial begin : result_sink
        int stall;
        position_word_t want;
        logic signed [COORD_W-1:0] got_x, got_y;
        logic [WP_IDX_W-1:0] got_seg;
        logic got_reached, got_finished;
        m_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 18);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got_x = m_tdata[23:0];
            got_y = m_tdata[47:24];
            got_seg = m_tdata[51:48];
            got_reached = m_tdata[52];
            got_finished = m_tdata[53];
            if (pending_positions.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: x=%0d y=%0d seg=%0d reached=%b finished=%b",
                             got_x, got_y, got_seg, got_reached, got_finished);
            end else begin
                want = pending_positions.pop_front();
                if (got_x !== want.pos_x || got_y !== want.pos_y || got_seg !== want.segment ||
                    got_reached !== want.reached || got_finished !== want.finished) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("mismatch: exp x=%0d y=%0d seg=%0d r=%b f=%b, ",
                               want.pos_x, want.pos_y, want.segment, want.reached,
                               want.finished);
                        $display("got x=%0d y=%0d seg=%0d r=%b f=%b",
                                 got_x, got_y, got_seg, got_reached, got_finished);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_TICK;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_START_X;
        cfg_wdata = '0;
        start_x_r = '0;
        start_y_r = '0;
        step_r = '0;
        count_r = '0;
        cur_x = '0;
        cur_y = '0;
        cur_seg = '0;
        for (int i = 0; i < MAX_WAYPOINTS; i++) begin
            table_x[i] = '0;
            table_y[i] = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_single_segment();
        test_zero_cases();
        test_saturation();
        test_random_paths();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_positions.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
